[hw/rtl/sprite_dma_line_sequencer_macros.svh]
// Assertion helpers shared by the sequencer RTL.
`ifndef SPRITE_DMA_LINE_SEQUENCER_MACROS_SVH
`define SPRITE_DMA_LINE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sdls_pkg.sv]
package sdls_pkg;

  // Fixed field widths.
  localparam int LINE_W     = 8;
  localparam int MASK_W     = 8;
  localparam int PTR_W      = 6;
  localparam int SEQ_MAX    = 8;
  localparam int YPOS_W     = LINE_W * SEQ_MAX;
  localparam int PTRS_W     = PTR_W * SEQ_MAX;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = YPOS_W;

  // Pointer value at which a sprite finishes its data fetch.
  localparam logic [PTR_W-1:0] PTR_LAST = 6'h3f;
  // Pointer increment of an advancing sprite.
  localparam logic [PTR_W-1:0] PTR_STEP = 6'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YEXP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YPOS   = 2'd2;

  // State of one sprite sequencer.
  typedef struct packed {
    logic             active;
    logic             toggle;
    logic             step;
    logic [PTR_W-1:0] pointer;
  } seq_state_t;

endpackage

[hw/rtl/sdls_channels.sv]
// Raster line channel.
interface sdls_in_if;
  import sdls_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] raster_line_low;
  modport source (output valid, output raster_line_low, input ready);
  modport sink (input valid, input raster_line_low, output ready);
endinterface

// Result channel.
interface sdls_out_if;
  import sdls_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] dma_active_mask;
  logic [MASK_W-1:0] expand_toggle_mask;
  logic [PTRS_W-1:0] sprite_pointers;
  modport source (output valid, output dma_active_mask, output expand_toggle_mask,
                  output sprite_pointers, input ready);
  modport sink (input valid, input dma_active_mask, input expand_toggle_mask,
                input sprite_pointers, output ready);
endinterface

// Configuration write channel.
interface sdls_cfg_if;
  import sdls_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/sdls_sprite.sv]
module sdls_sprite (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd,
  input  logic                enabled,
  input  logic                hit,
  input  logic                expanded,
  output sdls_pkg::seq_state_t seq_nxt
);
  import sdls_pkg::*;

  seq_state_t       seq_r;
  seq_state_t       start_st;
  logic [PTR_W-1:0] ptr_adv;
  logic             tog_adv;
  logic             trigger;

  // Values loaded when the sprite starts a new fetch.
  always_comb begin
    start_st.active  = 1'b1;
    start_st.pointer = '0;
    start_st.toggle  = ~expanded;
    start_st.step    = ~expanded;
  end

  assign trigger = enabled & hit;
  assign ptr_adv = seq_r.pointer + (seq_r.step ? PTR_STEP : '0);
  assign tog_adv = expanded ? ~seq_r.toggle : seq_r.toggle;

  // One line of sequencer update.
  always_comb begin
    seq_nxt = seq_r;
    if (trigger && !seq_r.active) begin
      seq_nxt = start_st;
    end else if (seq_r.active) begin
      seq_nxt.pointer = ptr_adv;
      seq_nxt.toggle  = tog_adv;
      seq_nxt.step    = tog_adv;
      if (ptr_adv == PTR_LAST) begin
        seq_nxt.active = 1'b0;
        if (trigger) begin
          seq_nxt = start_st;
        end
      end
    end
  end

  // State advances once per accepted raster line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (upd) begin
      seq_r <= seq_nxt;
    end
  end

endmodule

[hw/rtl/sprite_dma_line_sequencer.sv]
// Channel   Port     Dir  Transaction contents
// --------  -------  ---  ------------------------------------------------
// line      in_line  in   raster_line_low
// result    out_res  out  dma_active_mask, expand_toggle_mask, sprite_pointers
// config    cfg_wr   in   index, data (register write)
//
// One raster line per cycle while the result is not stalled; its result appears in the cycle after acceptance.
// The throughput is set by the single result register, refilled every cycle unless a stalled result holds it.
// Synchronous active-low reset clears all sprite state, the configuration registers and the result valid flag;
// the result payload registers are not reset. A stalled result blocks new lines only while the result register is full.
// Configuration writes are always taken.
`include "sprite_dma_line_sequencer_macros.svh"

module sprite_dma_line_sequencer #(
  parameter int SPRITE_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  sdls_in_if.sink   in_line,
  sdls_out_if.source out_res,
  sdls_cfg_if.sink  cfg_wr
);
  import sdls_pkg::*;

  logic [MASK_W-1:0] enable_r;
  logic [MASK_W-1:0] yexp_r;
  logic [YPOS_W-1:0] ypos_r;

  logic              in_acc;
  logic              out_valid_r;
  logic [MASK_W-1:0] act_r;
  logic [MASK_W-1:0] tog_r;
  logic [PTRS_W-1:0] ptrs_r;

  logic [MASK_W-1:0] act_nxt;
  logic [MASK_W-1:0] tog_nxt;
  logic [PTRS_W-1:0] ptrs_nxt;

  // Configuration register file.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      yexp_r   <= '0;
      ypos_r   <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_ENABLE: enable_r <= cfg_wr.data[MASK_W-1:0];
        REG_YEXP:   yexp_r   <= cfg_wr.data[MASK_W-1:0];
        REG_YPOS:   ypos_r   <= cfg_wr.data[YPOS_W-1:0];
        default: ;
      endcase
    end
  end

  // A line is taken whenever the result register is free or being drained.
  assign in_line.ready = !out_valid_r || out_res.ready;
  assign in_acc        = in_line.valid && in_line.ready;

  // Per-sprite sequencers; sprites beyond the count read as zero.
  for (genvar i = 0; i < SEQ_MAX; i++) begin : g_spr
    if (i < SPRITE_COUNT) begin : g_on
      seq_state_t st_nxt;

      sdls_sprite u_spr (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (in_acc),
        .enabled  (enable_r[i]),
        .hit      (ypos_r[LINE_W*i +: LINE_W] == in_line.raster_line_low),
        .expanded (yexp_r[i]),
        .seq_nxt  (st_nxt)
      );

      assign act_nxt[i]                = st_nxt.active;
      assign tog_nxt[i]                = st_nxt.toggle;
      assign ptrs_nxt[PTR_W*i +: PTR_W] = st_nxt.pointer;
    end else begin : g_off
      assign act_nxt[i]                = 1'b0;
      assign tog_nxt[i]                = 1'b0;
      assign ptrs_nxt[PTR_W*i +: PTR_W] = '0;
    end
  end

  // Result register: valid is control state, payload loads on acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= act_nxt;
      tog_r  <= tog_nxt;
      ptrs_r <= ptrs_nxt;
    end
  end

  assign out_res.valid              = out_valid_r;
  assign out_res.dma_active_mask    = act_r;
  assign out_res.expand_toggle_mask = tog_r;
  assign out_res.sprite_pointers    = ptrs_r;

  // Every accepted line yields a result in the next cycle.
  `SDLS_ASSERT_NEXT(a_line_gives_result, clk, rst_n, in_acc, out_valid_r, "line lost")

  // Sprites beyond the count never report anything.
  `SDLS_ASSERT_IMPL(a_unused_quiet, clk, rst_n, out_valid_r, ((act_r >> SPRITE_COUNT) == '0) && ((tog_r >> SPRITE_COUNT) == '0), "unused sprite reported")

  // An idle sprite sits either at its reset pointer or at the end pointer.
  for (genvar j = 0; j < SEQ_MAX; j++) begin : g_chk
    `SDLS_ASSERT_IMPL(a_idle_ptr, clk, rst_n, out_valid_r && !act_r[j], (ptrs_r[PTR_W*j +: PTR_W] == '0) || (ptrs_r[PTR_W*j +: PTR_W] == PTR_LAST), "idle sprite pointer")
  end

endmodule
